>>> src/tcpt_pkg.sv
package tcpt_pkg;

  // default coordinate width of the corner and probe ports
  localparam int unsigned COORD_WIDTH_DEF = 16;

  // result widths, fixed by the output format (centre signed Q24.0, radius unsigned Q23.0)
  localparam int unsigned CENTER_WIDTH = 24;
  localparam int unsigned RADIUS_WIDTH = 23;

  // recurrence steps done per pipeline stage
  localparam int unsigned SQRT_STEPS = 2;
  localparam int unsigned DIV_STEPS  = 2;

endpackage

>>> src/triangle_circumcircle_point_test_core.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+-------------------------------
// item in  | corner{0,1,2}_{x,y}_i, probe_{x,y}_i     | taken at an edge with start
//          |                                         | high and busy low
// item out | center_{x,y}_o, circle_radius_o,        | result_valid_o high for one
//          | inside_res_o, degenerate_o              | cycle, no back-pressure
//
// One item per cycle; busy stays low, nothing ever stalls.
// Pipeline depth is set by the square-root and divider recurrences.
// Reset clears only the valid bits of the pipeline.
module triangle_circumcircle_point_test_core #(
  parameter int unsigned COORD_WIDTH = tcpt_pkg::COORD_WIDTH_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic signed [COORD_WIDTH-1:0]            corner0_x_i,
  input  logic signed [COORD_WIDTH-1:0]            corner0_y_i,
  input  logic signed [COORD_WIDTH-1:0]            corner1_x_i,
  input  logic signed [COORD_WIDTH-1:0]            corner1_y_i,
  input  logic signed [COORD_WIDTH-1:0]            corner2_x_i,
  input  logic signed [COORD_WIDTH-1:0]            corner2_y_i,
  input  logic signed [COORD_WIDTH-1:0]            probe_x_i,
  input  logic signed [COORD_WIDTH-1:0]            probe_y_i,
  output logic                                     result_valid_o,
  output logic signed [tcpt_pkg::CENTER_WIDTH-1:0] center_x_o,
  output logic signed [tcpt_pkg::CENTER_WIDTH-1:0] center_y_o,
  output logic        [tcpt_pkg::RADIUS_WIDTH-1:0] circle_radius_o,
  output logic                                     inside_res_o,
  output logic                                     degenerate_o
);
  import tcpt_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;          // coordinate differences
  localparam int OW   = 2 * DW;         // orientation, 2x2 minors
  localparam int LSW  = 2 * DW + 1;     // squared lengths, kept signed
  localparam int NW   = 3 * W + 4;      // centre numerators, lifted minors
  localparam int MW   = NW - 1;         // numerator magnitude
  localparam int DDW  = OW + 1;         // d = 2*|orient|
  localparam int DETW = 4 * W + 5;      // incircle determinant
  localparam int NUMW = NW + 2;         // rounding numerator 2n+d
  localparam int NMW  = NW;             // its magnitude
  localparam int HL   = (MW + 1) / 2;   // split of magnitude for squaring
  localparam int HH   = MW - HL;
  localparam int R2W  = 2 * MW + 1;
  localparam int SQ_ST = (MW + 1 + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int SWP   = SQ_ST * SQRT_STEPS;
  localparam int CW    = CENTER_WIDTH;
  localparam int RW    = RADIUS_WIDTH;
  localparam int QB    = ((CW > W) ? CW : W) + 1;
  localparam int RQB   = RW;
  localparam int QMAX  = (QB > RQB) ? QB : RQB;
  localparam int DV_ST = (QMAX + DIV_STEPS - 1) / DIV_STEPS;
  localparam int CMPC  = NMW + QB + 1;
  localparam int CMPR  = SWP + RQB + 1;
  localparam int SUMW  = QB + 2;
  localparam int TOT   = 6 + SQ_ST + 1 + DV_ST + 1;

  typedef struct packed {
    logic                   degen;
    logic                   in_circ;
    logic [DDW-1:0]         d;
    logic signed [W-1:0]    x0;
    logic signed [W-1:0]    y0;
    logic                   cnegx;
    logic                   cnegy;
    logic                   covfx;
    logic                   covfy;
    logic [NMW-1:0]         cmagx;
    logic [NMW-1:0]         cmagy;
  } side_t;

  typedef struct packed {
    side_t                  sd;
    logic [SWP+1:0]         rem;
    logic [SWP-1:0]         res;
    logic [2*SWP-1:0]       op;
  } sq_t;

  typedef struct packed {
    logic                   degen;
    logic                   in_circ;
    logic [DDW-1:0]         d;
    logic signed [W-1:0]    x0;
    logic signed [W-1:0]    y0;
    logic                   cnegx;
    logic                   cnegy;
    logic                   covfx;
    logic                   covfy;
    logic [NMW-1:0]         rx;
    logic [NMW-1:0]         ry;
    logic [QB-1:0]          qx;
    logic [QB-1:0]          qy;
    logic [SWP-1:0]         rr;
    logic [RQB-1:0]         qr;
    logic                   rovf;
  } dv_t;

  assign busy = 1'b0;

  // valid bits, one per stage
  logic [TOT-1:0] vld_q, vld_d;
  assign vld_d = {vld_q[TOT-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------- stage 0: differences
  logic signed [DW-1:0] bx_q, by_q, cx_q, cy_q, ax_q, ay_q, qx_q, qy_q, sx_q, sy_q;
  logic signed [W-1:0]  x0_0_q, y0_0_q;

  always_ff @(posedge clk_i) begin
    bx_q   <= DW'(corner1_x_i) - DW'(corner0_x_i);
    by_q   <= DW'(corner1_y_i) - DW'(corner0_y_i);
    cx_q   <= DW'(corner2_x_i) - DW'(corner0_x_i);
    cy_q   <= DW'(corner2_y_i) - DW'(corner0_y_i);
    ax_q   <= DW'(corner0_x_i) - DW'(probe_x_i);
    ay_q   <= DW'(corner0_y_i) - DW'(probe_y_i);
    qx_q   <= DW'(corner1_x_i) - DW'(probe_x_i);
    qy_q   <= DW'(corner1_y_i) - DW'(probe_y_i);
    sx_q   <= DW'(corner2_x_i) - DW'(probe_x_i);
    sy_q   <= DW'(corner2_y_i) - DW'(probe_y_i);
    x0_0_q <= corner0_x_i;
    y0_0_q <= corner0_y_i;
  end

  // ---------------- stage 1: orientation, squared lengths, 2x2 minor
  logic signed [OW-1:0]  orient1_q, m1_1_q;
  logic signed [LSW-1:0] lb_q, lc_q, la1_q, lq_q, ls_q;
  logic signed [DW-1:0]  bx1_q, by1_q, cx1_q, cy1_q, ax1_q, ay1_q, qx1_q, qy1_q, sx1_q, sy1_q;
  logic signed [W-1:0]   x0_1_q, y0_1_q;

  always_ff @(posedge clk_i) begin
    orient1_q <= OW'(bx_q) * OW'(cy_q) - OW'(by_q) * OW'(cx_q);
    m1_1_q    <= OW'(qx_q) * OW'(sy_q) - OW'(sx_q) * OW'(qy_q);
    lb_q      <= LSW'(bx_q) * LSW'(bx_q) + LSW'(by_q) * LSW'(by_q);
    lc_q      <= LSW'(cx_q) * LSW'(cx_q) + LSW'(cy_q) * LSW'(cy_q);
    la1_q     <= LSW'(ax_q) * LSW'(ax_q) + LSW'(ay_q) * LSW'(ay_q);
    lq_q      <= LSW'(qx_q) * LSW'(qx_q) + LSW'(qy_q) * LSW'(qy_q);
    ls_q      <= LSW'(sx_q) * LSW'(sx_q) + LSW'(sy_q) * LSW'(sy_q);
    bx1_q <= bx_q; by1_q <= by_q; cx1_q <= cx_q; cy1_q <= cy_q;
    ax1_q <= ax_q; ay1_q <= ay_q; qx1_q <= qx_q; qy1_q <= qy_q;
    sx1_q <= sx_q; sy1_q <= sy_q;
    x0_1_q <= x0_0_q; y0_1_q <= y0_0_q;
  end

  // ---------------- stage 2: centre numerators, lifted minors
  logic signed [NW-1:0]  nx2_q, ny2_q, t1_q, t2_q;
  logic signed [OW-1:0]  orient2_q, m1_2_q;
  logic signed [LSW-1:0] la2_q;
  logic signed [DW-1:0]  ax2_q, ay2_q;
  logic signed [W-1:0]   x0_2_q, y0_2_q;

  always_ff @(posedge clk_i) begin
    nx2_q <= NW'(cy1_q) * NW'(lb_q) - NW'(by1_q) * NW'(lc_q);
    ny2_q <= NW'(bx1_q) * NW'(lc_q) - NW'(cx1_q) * NW'(lb_q);
    t1_q  <= NW'(qy1_q) * NW'(ls_q) - NW'(sy1_q) * NW'(lq_q);
    t2_q  <= NW'(qx1_q) * NW'(ls_q) - NW'(sx1_q) * NW'(lq_q);
    orient2_q <= orient1_q;
    m1_2_q    <= m1_1_q;
    la2_q     <= la1_q;
    ax2_q <= ax1_q; ay2_q <= ay1_q;
    x0_2_q <= x0_1_q; y0_2_q <= y0_1_q;
  end

  // ---------------- stage 3: incircle sign, d, sign-normalized numerators
  logic signed [DETW-1:0] det3;
  logic signed [OW-1:0]   orient_abs3;
  logic signed [NW-1:0]   nxs3, nys3, mx3, my3;
  logic                   inside3;

  always_comb begin
    det3 = DETW'(ax2_q) * DETW'(t1_q) - DETW'(ay2_q) * DETW'(t2_q)
         + DETW'(la2_q) * DETW'(m1_2_q);
    // clockwise corners flip the determinant sign
    if (orient2_q[OW-1]) begin
      inside3 = det3[DETW-1] || (det3 == '0);
    end else begin
      inside3 = !det3[DETW-1];
    end
    orient_abs3 = orient2_q[OW-1] ? -orient2_q : orient2_q;
    nxs3 = orient2_q[OW-1] ? -nx2_q : nx2_q;
    nys3 = orient2_q[OW-1] ? -ny2_q : ny2_q;
    mx3  = nx2_q[NW-1] ? -nx2_q : nx2_q;
    my3  = ny2_q[NW-1] ? -ny2_q : ny2_q;
  end

  logic                 degen3_q, inside3_q;
  logic [DDW-1:0]       d3_q;
  logic signed [NW-1:0] nxs3_q, nys3_q;
  logic [MW-1:0]        mx3_q, my3_q;
  logic signed [W-1:0]  x0_3_q, y0_3_q;

  always_ff @(posedge clk_i) begin
    degen3_q  <= (orient2_q == '0);
    inside3_q <= inside3 && (orient2_q != '0);
    d3_q      <= {orient_abs3, 1'b0};
    nxs3_q    <= nxs3;
    nys3_q    <= nys3;
    mx3_q     <= mx3[MW-1:0];
    my3_q     <= my3[MW-1:0];
    x0_3_q    <= x0_2_q;
    y0_3_q    <= y0_2_q;
  end

  // ---------------- stage 4: partial products of the squares, rounding numerators
  logic signed [NUMW-1:0] numx4, numy4, absx4, absy4;

  always_comb begin
    numx4 = (NUMW'(nxs3_q) <<< 1) + NUMW'($signed({1'b0, d3_q}));
    numy4 = (NUMW'(nys3_q) <<< 1) + NUMW'($signed({1'b0, d3_q}));
    absx4 = numx4[NUMW-1] ? -numx4 : numx4;
    absy4 = numy4[NUMW-1] ? -numy4 : numy4;
  end

  logic [2*HH-1:0]    hhx_q, hhy_q;
  logic [HH+HL-1:0]   hlx_q, hly_q;
  logic [2*HL-1:0]    llx_q, lly_q;
  side_t              sd4_q;

  always_ff @(posedge clk_i) begin
    hhx_q <= (2*HH)'(mx3_q[MW-1:HL]) * (2*HH)'(mx3_q[MW-1:HL]);
    hlx_q <= (HH+HL)'(mx3_q[MW-1:HL]) * (HH+HL)'(mx3_q[HL-1:0]);
    llx_q <= (2*HL)'(mx3_q[HL-1:0]) * (2*HL)'(mx3_q[HL-1:0]);
    hhy_q <= (2*HH)'(my3_q[MW-1:HL]) * (2*HH)'(my3_q[MW-1:HL]);
    hly_q <= (HH+HL)'(my3_q[MW-1:HL]) * (HH+HL)'(my3_q[HL-1:0]);
    lly_q <= (2*HL)'(my3_q[HL-1:0]) * (2*HL)'(my3_q[HL-1:0]);
    sd4_q.degen   <= degen3_q;
    sd4_q.in_circ <= inside3_q;
    sd4_q.d       <= d3_q;
    sd4_q.x0      <= x0_3_q;
    sd4_q.y0      <= y0_3_q;
    sd4_q.cnegx   <= numx4[NUMW-1];
    sd4_q.cnegy   <= numy4[NUMW-1];
    sd4_q.covfx   <= 1'b0;
    sd4_q.covfy   <= 1'b0;
    sd4_q.cmagx   <= absx4[NMW-1:0];
    sd4_q.cmagy   <= absy4[NMW-1:0];
  end

  // ---------------- stage 5: nx^2 + ny^2, quotient range checks
  logic [R2W-1:0] r2_5_q;
  side_t          sd5_d, sd5_q;

  always_comb begin
    sd5_d       = sd4_q;
    // quotient of |2n+d| / 2d would not fit QB bits
    sd5_d.covfx = CMPC'(sd4_q.cmagx) >= (CMPC'(sd4_q.d) << (QB + 1));
    sd5_d.covfy = CMPC'(sd4_q.cmagy) >= (CMPC'(sd4_q.d) << (QB + 1));
  end

  always_ff @(posedge clk_i) begin
    r2_5_q <= (R2W'(hhx_q) << (2*HL)) + (R2W'(hlx_q) << (HL+1)) + R2W'(llx_q)
            + (R2W'(hhy_q) << (2*HL)) + (R2W'(hly_q) << (HL+1)) + R2W'(lly_q);
    sd5_q  <= sd5_d;
  end

  // ---------------- integer square root, SQRT_STEPS result bits per stage
  sq_t sq_init;
  sq_t sq_src [SQ_ST];
  sq_t sq_d   [SQ_ST];
  sq_t sq_q   [SQ_ST];

  always_comb begin
    sq_init     = '0;
    sq_init.sd  = sd5_q;
    sq_init.op  = (2*SWP)'(r2_5_q);
  end

  for (genvar j = 0; j < SQ_ST; j++) begin : g_sq
    if (j == 0) begin : g_first
      assign sq_src[j] = sq_init;
    end else begin : g_next
      assign sq_src[j] = sq_q[j-1];
    end

    always_comb begin
      logic [SWP+1:0] trial;
      sq_d[j] = sq_src[j];
      for (int t = 0; t < SQRT_STEPS; t++) begin
        sq_d[j].rem = {sq_d[j].rem[SWP-1:0], sq_d[j].op[2*SWP-1 -: 2]};
        sq_d[j].op  = sq_d[j].op << 2;
        trial       = {sq_d[j].res, 2'b01};
        if (sq_d[j].rem >= trial) begin
          sq_d[j].rem = sq_d[j].rem - trial;
          sq_d[j].res = {sq_d[j].res[SWP-2:0], 1'b1};
        end else begin
          sq_d[j].res = {sq_d[j].res[SWP-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[j] <= sq_d[j];
    end
  end

  // ---------------- divider entry
  dv_t dv_init_d, dv_init_q;

  always_comb begin
    dv_init_d         = '0;
    dv_init_d.degen   = sq_q[SQ_ST-1].sd.degen;
    dv_init_d.in_circ = sq_q[SQ_ST-1].sd.in_circ;
    dv_init_d.d       = sq_q[SQ_ST-1].sd.d;
    dv_init_d.x0      = sq_q[SQ_ST-1].sd.x0;
    dv_init_d.y0      = sq_q[SQ_ST-1].sd.y0;
    dv_init_d.cnegx   = sq_q[SQ_ST-1].sd.cnegx;
    dv_init_d.cnegy   = sq_q[SQ_ST-1].sd.cnegy;
    dv_init_d.covfx   = sq_q[SQ_ST-1].sd.covfx;
    dv_init_d.covfy   = sq_q[SQ_ST-1].sd.covfy;
    dv_init_d.rx      = sq_q[SQ_ST-1].sd.cmagx;
    dv_init_d.ry      = sq_q[SQ_ST-1].sd.cmagy;
    dv_init_d.rr      = sq_q[SQ_ST-1].res;
    // floor(s/d) would exceed the radius range
    dv_init_d.rovf    = CMPR'(sq_q[SQ_ST-1].res)
                      >= (CMPR'(sq_q[SQ_ST-1].sd.d) << RQB);
  end

  always_ff @(posedge clk_i) begin
    dv_init_q <= dv_init_d;
  end

  // ---------------- restoring dividers: centre x, centre y, radius
  dv_t dv_src [DV_ST];
  dv_t dv_d   [DV_ST];
  dv_t dv_q   [DV_ST];

  for (genvar j = 0; j < DV_ST; j++) begin : g_dv
    if (j == 0) begin : g_first
      assign dv_src[j] = dv_init_q;
    end else begin : g_next
      assign dv_src[j] = dv_q[j-1];
    end

    always_comb begin
      int k;
      logic [CMPC-1:0] dshc;
      logic [CMPR-1:0] dshr;
      dv_d[j] = dv_src[j];
      for (int t = 0; t < DIV_STEPS; t++) begin
        k = j * DIV_STEPS + t;
        if (k < QB) begin
          // divisor is 2d
          dshc = CMPC'(dv_d[j].d) << (QB - k);
          if (CMPC'(dv_d[j].rx) >= dshc) begin
            dv_d[j].rx         = dv_d[j].rx - dshc[NMW-1:0];
            dv_d[j].qx[QB-1-k] = 1'b1;
          end
          if (CMPC'(dv_d[j].ry) >= dshc) begin
            dv_d[j].ry         = dv_d[j].ry - dshc[NMW-1:0];
            dv_d[j].qy[QB-1-k] = 1'b1;
          end
        end
        if (k < RQB) begin
          dshr = CMPR'(dv_d[j].d) << (RQB - 1 - k);
          if (CMPR'(dv_d[j].rr) >= dshr) begin
            dv_d[j].rr          = dv_d[j].rr - dshr[SWP-1:0];
            dv_d[j].qr[RQB-1-k] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[j] <= dv_d[j];
    end
  end

  // ---------------- output: sign, add corner 0, saturate
  localparam logic signed [SUMW-1:0] CMAX = SUMW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [SUMW-1:0] CMIN = -CMAX - SUMW'(1);

  dv_t                    fin;
  logic [QB-1:0]          magx, magy;
  logic signed [SUMW-1:0] sumx, sumy, satx, saty;

  always_comb begin
    fin  = dv_q[DV_ST-1];
    magx = fin.covfx ? '1 : fin.qx;
    magy = fin.covfy ? '1 : fin.qy;
    // negative numerator: floor is -(ceil of the magnitude quotient)
    sumx = SUMW'(fin.x0) + (fin.cnegx
         ? -SUMW'({1'b0, magx}) - SUMW'({1'b0, (fin.rx != '0)})
         :  SUMW'({1'b0, magx}));
    sumy = SUMW'(fin.y0) + (fin.cnegy
         ? -SUMW'({1'b0, magy}) - SUMW'({1'b0, (fin.ry != '0)})
         :  SUMW'({1'b0, magy}));
    satx = (sumx > CMAX) ? CMAX : ((sumx < CMIN) ? CMIN : sumx);
    saty = (sumy > CMAX) ? CMAX : ((sumy < CMIN) ? CMIN : sumy);
  end

  always_ff @(posedge clk_i) begin
    if (fin.degen) begin
      center_x_o      <= '0;
      center_y_o      <= '0;
      circle_radius_o <= '0;
      inside_res_o    <= 1'b0;
    end else begin
      center_x_o      <= satx[CW-1:0];
      center_y_o      <= saty[CW-1:0];
      circle_radius_o <= fin.rovf ? '1 : fin.qr;
      inside_res_o    <= fin.in_circ;
    end
    degenerate_o <= fin.degen;
  end

  assign result_valid_o = vld_q[TOT-1];

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && degenerate_o |->
      center_x_o == '0 && center_y_o == '0 && circle_radius_o == '0 && !inside_res_o)
    else $error("degenerate item with nonzero circle fields");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##TOT result_valid_o)
    else $error("accepted item did not produce a result at the pipeline depth");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start |-> ##TOT !result_valid_o)
    else $error("result strobe without a matching accepted item");
`endif

endmodule
